// ===== rtl/polygon_signed_distance_top_defines.svh =====
// ----------------------------------------------------------------------------
// polygon_signed_distance_top_defines
// Assertion macros used by the checker file of the polygon distance block.
// ----------------------------------------------------------------------------
`ifndef POLYGON_SIGNED_DISTANCE_TOP_DEFINES_SVH
`define POLYGON_SIGNED_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define PSD_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define PSD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Widths, reset values and transaction types of the polygon distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int NREG    = 8;
   localparam int VIDX_W  = 3;
   localparam int CSR_W   = 32;
   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int LEN_W   = PROD_W;
   localparam int HALF_W  = LEN_W / 2;
   localparam int CSQ_W   = 2 * LEN_W;
   localparam int QUO_W   = LEN_W;
   localparam int ROOT_W  = QUO_W / 2;
   localparam int SQR_W   = ROOT_W + 3;
   localparam int SD_W    = 18;

   localparam int DEF_NUM_VERTICES = 8;

   localparam logic [SD_W-1:0] DIST_POS_MAX = SD_W'((2 ** (SD_W - 1)) - 1);
   localparam logic [SD_W-1:0] DIST_NEG_MAG = SD_W'(2 ** (SD_W - 1));

   localparam logic [CSR_W-1:0] VERTEX_RESET [NREG] = '{
      32'd843379924,  32'd843320108,  32'd459153795,  32'd3835830659,
      32'd3451652908, 32'd3451712724, 32'd3835879037, 32'd459202173
   };

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type xa;
      coord_type ya;
      coord_type xb;
      coord_type yb;
      coord_type px;
      coord_type py;
      logic      first;
      logic      last;
   } edge_type;

   typedef struct packed {
      logic             first;
      logic             last;
      logic             xing;
      logic             skip;
      logic             proj;
      logic [LEN_W-1:0] alt;
   } side_type;

   typedef struct packed {
      logic [LEN_W-1:0] len2;
      logic [CSQ_W-1:0] csq;
      side_type         side;
   } div_in_type;

   typedef struct packed {
      logic [QUO_W-1:0] quo;
      side_type         side;
   } div_out_type;

endpackage

// ===== rtl/psd_edge_seq.sv =====
// ----------------------------------------------------------------------------
// psd_edge_seq
// Vertex registers and sequencer: one edge a cycle per point while adv holds.
// ----------------------------------------------------------------------------
module psd_edge_seq
   import psd_pkg::*;
#(
   parameter int NUM_VERTICES = DEF_NUM_VERTICES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              csr_we,
   input  logic [VIDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  logic              req_valid,
   output logic              req_ready,
   input  coord_type         req_pos_x,
   input  coord_type         req_pos_y,
   output logic              edge_valid,
   output edge_type          edge_out
);

   localparam int EW = $clog2(NUM_VERTICES);
   localparam logic [EW-1:0]     LAST_STEP = EW'(NUM_VERTICES - 1);
   localparam logic [VIDX_W-1:0] WRAP_IDX  = VIDX_W'(NUM_VERTICES - 1);

   logic [CSR_W-1:0] vertex_ff [NREG];
   logic             busy_ff, busy_in;
   logic [EW-1:0]    step_ff, step_in;
   coord_type        px_ff, py_ff;
   logic [CSR_W-1:0] prev_ff;
   logic             edge_valid_ff;
   edge_type         edge_ff, edge_in;
   logic [CSR_W-1:0] cur_v, a_v;
   logic             accept, at_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_ff <= VERTEX_RESET;
      end else if (csr_we) begin
         vertex_ff[csr_index] <= csr_wdata;
      end
   end

   assign at_last   = (step_ff == LAST_STEP);
   assign req_ready = adv && (!busy_ff || at_last);
   assign accept    = req_valid && req_ready;
   assign cur_v     = vertex_ff[VIDX_W'(step_ff)];
   assign a_v       = (step_ff == '0) ? vertex_ff[WRAP_IDX] : prev_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (adv) begin
         if (busy_ff && !at_last) begin
            step_in = step_ff + 1'b1;
         end else begin
            busy_in = accept;
            step_in = '0;
         end
      end
      edge_in.xa    = a_v[COORD_W-1:0];
      edge_in.ya    = a_v[CSR_W-1:COORD_W];
      edge_in.xb    = cur_v[COORD_W-1:0];
      edge_in.yb    = cur_v[CSR_W-1:COORD_W];
      edge_in.px    = px_ff;
      edge_in.py    = py_ff;
      edge_in.first = (step_ff == '0);
      edge_in.last  = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         step_ff       <= '0;
         edge_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         if (adv) begin
            edge_valid_ff <= busy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
      end
      if (adv) begin
         prev_ff <= cur_v;
         edge_ff <= edge_in;
      end
   end

   assign edge_valid = edge_valid_ff;
   assign edge_out   = edge_ff;

endmodule

// ===== rtl/psd_geom.sv =====
// ----------------------------------------------------------------------------
// psd_geom
// Six-stage edge geometry: differences, products, sums, case select, cross^2.
// ----------------------------------------------------------------------------
module psd_geom
   import psd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_valid,
   input  edge_type   edge_in,
   output logic       out_valid,
   output div_in_type out_data
);

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef struct packed {
      diff_type dx, dy, ex, ey, fx, fy;
      logic     straddle, dypos, first, last;
   } s1_type;

   typedef struct packed {
      prod_type mdx2, mdy2, mexdx, meydy, mexdy, meydx, mex2, mey2, mfx2, mfy2;
      logic     straddle, dypos, first, last;
   } s2_type;

   typedef struct packed {
      logic [LEN_W-1:0] len2, de2, df2;
      sum_type          dot, cr;
      logic             straddle, dypos, first, last;
   } s3_type;

   typedef struct packed {
      logic [LEN_W-1:0] len2;
      logic [LEN_W-1:0] cabs;
      side_type         side;
   } s4_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len2;
      logic [PROD_W-1:0] hh, hl, ll;
      side_type          side;
   } s5_type;

   s1_type     s1_ff, s1_in;
   s2_type     s2_ff, s2_in;
   s3_type     s3_ff, s3_in;
   s4_type     s4_ff, s4_in;
   s5_type     s5_ff, s5_in;
   div_in_type s6_ff, s6_in;
   logic [5:0] valid_ff;
   logic [HALF_W-1:0] c_hi, c_lo;

   // geometry differences and the half-open straddle test
   always_comb begin
      s1_in.dx       = DIFF_W'(edge_in.xb) - DIFF_W'(edge_in.xa);
      s1_in.dy       = DIFF_W'(edge_in.yb) - DIFF_W'(edge_in.ya);
      s1_in.ex       = DIFF_W'(edge_in.px) - DIFF_W'(edge_in.xa);
      s1_in.ey       = DIFF_W'(edge_in.py) - DIFF_W'(edge_in.ya);
      s1_in.fx       = DIFF_W'(edge_in.px) - DIFF_W'(edge_in.xb);
      s1_in.fy       = DIFF_W'(edge_in.py) - DIFF_W'(edge_in.yb);
      s1_in.straddle = (edge_in.ya > edge_in.py) != (edge_in.yb > edge_in.py);
      s1_in.dypos    = (edge_in.yb > edge_in.ya);
      s1_in.first    = edge_in.first;
      s1_in.last     = edge_in.last;
   end

   always_comb begin
      s2_in.mdx2     = PROD_W'(s1_ff.dx) * PROD_W'(s1_ff.dx);
      s2_in.mdy2     = PROD_W'(s1_ff.dy) * PROD_W'(s1_ff.dy);
      s2_in.mexdx    = PROD_W'(s1_ff.ex) * PROD_W'(s1_ff.dx);
      s2_in.meydy    = PROD_W'(s1_ff.ey) * PROD_W'(s1_ff.dy);
      s2_in.mexdy    = PROD_W'(s1_ff.ex) * PROD_W'(s1_ff.dy);
      s2_in.meydx    = PROD_W'(s1_ff.ey) * PROD_W'(s1_ff.dx);
      s2_in.mex2     = PROD_W'(s1_ff.ex) * PROD_W'(s1_ff.ex);
      s2_in.mey2     = PROD_W'(s1_ff.ey) * PROD_W'(s1_ff.ey);
      s2_in.mfx2     = PROD_W'(s1_ff.fx) * PROD_W'(s1_ff.fx);
      s2_in.mfy2     = PROD_W'(s1_ff.fy) * PROD_W'(s1_ff.fy);
      s2_in.straddle = s1_ff.straddle;
      s2_in.dypos    = s1_ff.dypos;
      s2_in.first    = s1_ff.first;
      s2_in.last     = s1_ff.last;
   end

   always_comb begin
      s3_in.len2     = LEN_W'(s2_ff.mdx2 + s2_ff.mdy2);
      s3_in.de2      = LEN_W'(s2_ff.mex2 + s2_ff.mey2);
      s3_in.df2      = LEN_W'(s2_ff.mfx2 + s2_ff.mfy2);
      s3_in.dot      = SUM_W'(s2_ff.mexdx) + SUM_W'(s2_ff.meydy);
      s3_in.cr       = SUM_W'(s2_ff.mexdy) - SUM_W'(s2_ff.meydx);
      s3_in.straddle = s2_ff.straddle;
      s3_in.dypos    = s2_ff.dypos;
      s3_in.first    = s2_ff.first;
      s3_in.last     = s2_ff.last;
   end

   // endpoint or perpendicular foot; the cross product sign gives the crossing
   always_comb begin
      s4_in.len2       = s3_ff.len2;
      s4_in.cabs       = s3_ff.cr[SUM_W-1] ? LEN_W'(-s3_ff.cr) : LEN_W'(s3_ff.cr);
      s4_in.side.first = s3_ff.first;
      s4_in.side.last  = s3_ff.last;
      s4_in.side.skip  = (s3_ff.len2 == '0);
      s4_in.side.proj  = (s3_ff.dot > 0) && (s3_ff.dot < $signed({1'b0, s3_ff.len2}));
      s4_in.side.alt   = (s3_ff.dot <= 0) ? s3_ff.de2 : s3_ff.df2;
      s4_in.side.xing  = s3_ff.straddle &&
                         (s3_ff.dypos ? (s3_ff.cr < 0) : (s3_ff.cr > 0));
   end

   assign c_hi = s4_ff.cabs[LEN_W-1:HALF_W];
   assign c_lo = s4_ff.cabs[HALF_W-1:0];

   always_comb begin
      s5_in.len2 = s4_ff.len2;
      s5_in.hh   = PROD_W'(c_hi) * PROD_W'(c_hi);
      s5_in.hl   = PROD_W'(c_hi) * PROD_W'(c_lo);
      s5_in.ll   = PROD_W'(c_lo) * PROD_W'(c_lo);
      s5_in.side = s4_ff.side;
   end

   always_comb begin
      s6_in.len2 = s5_ff.len2;
      s6_in.csq  = (CSQ_W'(s5_ff.hh) << (2 * HALF_W)) +
                   (CSQ_W'(s5_ff.hl) << (HALF_W + 1)) + CSQ_W'(s5_ff.ll);
      s6_in.side = s5_ff.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_data  = s6_ff;

endmodule

// ===== rtl/psd_div.sv =====
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, one quotient bit a stage: cross^2 / len^2.
// ----------------------------------------------------------------------------
module psd_div
   import psd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  div_in_type  in_data,
   output logic        out_valid,
   output div_out_type out_data
);

   typedef struct packed {
      logic [LEN_W-1:0] len2;
      logic [LEN_W-1:0] rem;
      logic [LEN_W-1:0] low;
      logic [QUO_W-1:0] quo;
      side_type         side;
   } stage_type;

   stage_type        stage_ff [QUO_W];
   stage_type        stage_in [QUO_W];
   stage_type        src;
   logic [QUO_W-1:0] valid_ff;
   logic [LEN_W:0]   trial;
   logic             ge;

   always_comb begin
      src   = '0;
      trial = '0;
      ge    = 1'b0;
      for (int k = 0; k < QUO_W; k++) begin
         if (k == 0) begin
            src.len2 = in_data.len2;
            src.rem  = in_data.csq[CSQ_W-1:LEN_W];
            src.low  = in_data.csq[LEN_W-1:0];
            src.quo  = '0;
            src.side = in_data.side;
         end else begin
            src = stage_ff[k-1];
         end
         trial              = {src.rem, src.low[LEN_W-1]};
         ge                 = (trial >= {1'b0, src.len2});
         stage_in[k].len2   = src.len2;
         stage_in[k].rem    = ge ? LEN_W'(trial - {1'b0, src.len2}) : trial[LEN_W-1:0];
         stage_in[k].low    = {src.low[LEN_W-2:0], 1'b0};
         stage_in[k].quo    = {src.quo[QUO_W-2:0], ge};
         stage_in[k].side   = src.side;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[QUO_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid     = valid_ff[QUO_W-1];
   assign out_data.quo  = stage_ff[QUO_W-1].quo;
   assign out_data.side = stage_ff[QUO_W-1].side;

endmodule

// ===== rtl/psd_reduce.sv =====
// ----------------------------------------------------------------------------
// psd_reduce
// Least squared distance over an item's edges, pipelined floor root, sign.
// ----------------------------------------------------------------------------
module psd_reduce
   import psd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  div_out_type            in_data,
   output logic                   res_valid,
   output logic                   res_inside,
   output logic signed [SD_W-1:0] res_sd
);

   typedef struct packed {
      logic [QUO_W-1:0]  rad;
      logic [SQR_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic              found;
      logic              in_poly;
   } sq_type;

   logic              found_ff, found_in, par_ff, par_in;
   logic [QUO_W-1:0]  best_ff, best_in, d2, base_best;
   logic              base_found, base_par;
   sq_type            sq_ff [ROOT_W];
   sq_type            sq_in [ROOT_W];
   sq_type            src;
   logic [ROOT_W-1:0] sq_valid_ff;
   logic [SQR_W-1:0]  rem2, tv;
   logic              ge;
   logic              res_valid_ff, res_inside_ff;
   logic [SD_W-1:0]   res_sd_ff, res_sd_in, mag;
   sq_type            tail;

   // fold this edge into the running minimum and crossing parity
   always_comb begin
      base_found = in_data.side.first ? 1'b0 : found_ff;
      base_par   = in_data.side.first ? 1'b0 : par_ff;
      base_best  = best_ff;
      d2         = in_data.side.proj ? in_data.quo : in_data.side.alt;
      found_in   = base_found | !in_data.side.skip;
      best_in    = (!in_data.side.skip && (!base_found || d2 < base_best)) ? d2 : base_best;
      par_in     = base_par ^ in_data.side.xing;
   end

   always_comb begin
      src  = '0;
      rem2 = '0;
      tv   = '0;
      ge   = 1'b0;
      for (int k = 0; k < ROOT_W; k++) begin
         if (k == 0) begin
            src.rad     = best_in;
            src.rem     = '0;
            src.root    = '0;
            src.found   = found_in;
            src.in_poly = par_in;
         end else begin
            src = sq_ff[k-1];
         end
         rem2              = {src.rem[SQR_W-3:0], src.rad[QUO_W-1:QUO_W-2]};
         tv                = SQR_W'({src.root, 2'b01});
         ge                = (rem2 >= tv);
         sq_in[k].rad      = {src.rad[QUO_W-3:0], 2'b00};
         sq_in[k].rem      = ge ? (rem2 - tv) : rem2;
         sq_in[k].root     = {src.root[ROOT_W-2:0], ge};
         sq_in[k].found    = src.found;
         sq_in[k].in_poly  = src.in_poly;
      end
   end

   assign tail = sq_ff[ROOT_W-1];

   always_comb begin
      if (tail.found) begin
         mag = SD_W'(tail.root);
      end else if (tail.in_poly) begin
         mag = DIST_POS_MAX;
      end else begin
         mag = DIST_NEG_MAG;
      end
      res_sd_in = tail.in_poly ? mag : SD_W'(-mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         par_ff       <= 1'b0;
         sq_valid_ff  <= '0;
         res_valid_ff <= 1'b0;
      end else if (adv) begin
         if (in_valid) begin
            found_ff <= found_in;
            par_ff   <= par_in;
         end
         sq_valid_ff  <= {sq_valid_ff[ROOT_W-2:0], in_valid && in_data.side.last};
         res_valid_ff <= sq_valid_ff[ROOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (in_valid) begin
            best_ff <= best_in;
         end
         sq_ff         <= sq_in;
         res_inside_ff <= tail.in_poly;
         res_sd_ff     <= res_sd_in;
      end
   end

   assign res_valid  = res_valid_ff;
   assign res_inside = res_inside_ff;
   assign res_sd     = $signed(res_sd_ff);

endmodule

// ===== rtl/polygon_signed_distance_top.sv =====
// ----------------------------------------------------------------------------
// polygon_signed_distance_top
// Point-in-polygon test and signed distance to the boundary, one joint
// position (pos_x, pos_y, signed fixed point) per request transaction. Each
// transaction returns inside_res by half-open ray casting and the signed
// distance to the nearest edge segment (positive inside, negative outside,
// floor of the exact Euclidean distance, full scale when every edge has zero
// length). The polygon is NUM_VERTICES vertices taken from csr registers 0 up,
// each packed y in bits 31:16 and x in bits 15:0; registers reset to a default
// octagon. The user must write them only while no transaction is in flight;
// the block does not enforce this. The edge sequencer feeds one edge a cycle,
// while the pipeline is not stalled, into a single shared edge datapath. Most
// of the pipeline depth lies in the 34-stage divider and the 17-stage square
// root. A new request is taken while earlier ones are still in the pipeline,
// and a skid stage behind the response register parks one result so the
// pipeline keeps running when response back-pressure first arrives.
// ----------------------------------------------------------------------------
module polygon_signed_distance_top
   import psd_pkg::*;
#(
   parameter int NUM_VERTICES = DEF_NUM_VERTICES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [VIDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  coord_type              req_pos_x,
   input  coord_type              req_pos_y,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_inside_res,
   output logic signed [SD_W-1:0] rsp_signed_distance
);

   logic                   adv;
   logic                   edge_valid, geom_valid, div_valid, res_valid;
   edge_type               edge_data;
   div_in_type             geom_data;
   div_out_type            div_data;
   logic                   res_inside;
   logic signed [SD_W-1:0] res_sd;
   logic                   take, rsp_free;

   logic                   rsp_valid_ff, rsp_inside_ff;
   logic signed [SD_W-1:0] rsp_sd_ff;
   logic                   skid_valid_ff, skid_inside_ff;
   logic signed [SD_W-1:0] skid_sd_ff;

   // The whole pipeline advances together while the skid stage is empty.
   assign adv      = !skid_valid_ff;
   assign take     = res_valid && adv;
   assign rsp_free = rsp_ready || !rsp_valid_ff;

   psd_edge_seq #(
      .NUM_VERTICES(NUM_VERTICES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .edge_valid (edge_valid),
      .edge_out   (edge_data)
   );

   psd_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (edge_valid),
      .edge_in   (edge_data),
      .out_valid (geom_valid),
      .out_data  (geom_data)
   );

   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (geom_valid),
      .in_data   (geom_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   psd_reduce u_reduce (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (div_valid),
      .in_data    (div_data),
      .res_valid  (res_valid),
      .res_inside (res_inside),
      .res_sd     (res_sd)
   );

   // Response register: refill from the skid stage first, then from the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (rsp_free) begin
            rsp_valid_ff <= skid_valid_ff || take;
         end
         if (skid_valid_ff) begin
            if (rsp_free) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (take && !rsp_free) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_inside_ff <= skid_inside_ff;
            rsp_sd_ff     <= skid_sd_ff;
         end else begin
            rsp_inside_ff <= res_inside;
            rsp_sd_ff     <= res_sd;
         end
      end
      // park the result when the response register is still held
      if (!skid_valid_ff && take && !rsp_free) begin
         skid_inside_ff <= res_inside;
         skid_sd_ff     <= res_sd;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_inside_res      = rsp_inside_ff;
   assign rsp_signed_distance = rsp_sd_ff;

endmodule

// ===== rtl/psd_checker.sv =====
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on the polygon distance block, bound to the top level.
// ----------------------------------------------------------------------------
`include "polygon_signed_distance_top_defines.svh"

module psd_checker
   import psd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_inside_res,
   input logic signed [SD_W-1:0] rsp_signed_distance
);

   `PSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_signed_distance) && $stable(rsp_inside_res), "response dropped or changed while stalled")

   `PSD_ASSERT_NOW(a_rsp_after_reset, clock, reset, $past(reset), !rsp_valid, "response valid right after reset")

   `PSD_ASSERT_NOW(a_inside_sign, clock, reset, rsp_valid && rsp_inside_res, !rsp_signed_distance[SD_W-1], "inside point with negative distance")

   `PSD_ASSERT_NOW(a_outside_sign, clock, reset, rsp_valid && !rsp_inside_res, rsp_signed_distance[SD_W-1] || (rsp_signed_distance == '0), "outside point with positive distance")

endmodule

bind polygon_signed_distance_top psd_checker u_psd_checker (.*);
